### rtl/iba_pkg.sv
// Shared types, sizes and codes of the inode block allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package iba_pkg;
    localparam int SLOTS = 16;
    localparam int SLOT_W = 4;
    localparam int BLOCKS = 128;
    localparam int BLK_W = 7;
    localparam int PER_FILE = 8;
    localparam int PTR_IDX_W = 3;
    localparam int PTR_ADDR_W = SLOT_W + PTR_IDX_W;
    localparam int CNT_W = 4;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_RESOLVE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PARTIAL   = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_NO_BLOCK  = 3'd5,
        ST_BAD_SIZE  = 3'd6
    } status_t;

    // Name ends at the first zero byte.
    function automatic logic [63:0] clean_name(input logic [63:0] n);
        logic [63:0] r;
        logic        stop;
        r = '0;
        stop = 1'b0;
        for (int b = 0; b < 8; b++)
        begin
            if (n[8*b +: 8] == 8'd0)
                stop = 1'b1;
            if (!stop)
                r[8*b +: 8] = n[8*b +: 8];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/iba_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module iba_ram #(
    parameter int DEPTH = 16,
    parameter int AW = 4,
    parameter int DW = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [DW-1:0] wdata,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### rtl/inode_block_allocator.sv
// Top level of the inode block allocator: sequencer, entry flags and bitmap.
// Depends on iba_pkg and iba_ram.
//
// Channel | Dir | tdata fields (lowest bit first)
// s_axis  | in  | command[1:0] file_name[65:2] block_count[69:66] block_index[72:70]
// m_axis  | out | status[2:0] physical_block[9:3] blocks_given[13:10] slot[17:14]
//
// One item at a time. A name search reads the name memory one entry a cycle.
// Create then clears 8 pointers and sweeps the busy bitmap one block a cycle;
// delete walks 8 pointers, then clears them. After reset a pass clears the
// pointer memory before the first item is taken. A result held on m_axis
// stalls the block until taken.
`timescale 1ns / 1ps
`default_nettype none
module inode_block_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // command, file_name, block_count, block_index
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // status, physical_block, blocks_given, slot
);
    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_SEARCH  = 10'b0000000100,
        S_DECIDE  = 10'b0000001000,
        S_ALLOC   = 10'b0000010000,
        S_WIPE    = 10'b0000100000,
        S_FREE    = 10'b0001000000,
        S_FREEW   = 10'b0010000000,
        S_RESOLVE = 10'b0100000000,
        S_OUT     = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  cmd_reg;
    logic [63:0] name_reg;
    logic [3:0]  count_reg;
    logic [2:0]  index_reg;

    logic [iba_pkg::SLOTS-1:0]  used_reg;
    logic [iba_pkg::BLOCKS-1:0] busy_reg;

    logic [iba_pkg::SLOT_W:0]   scan_reg;   // one wider so it can reach the end
    logic                       hit_reg;
    logic [iba_pkg::SLOT_W-1:0] hit_slot_reg;
    logic [iba_pkg::SLOT_W-1:0] slot_reg;
    logic [iba_pkg::BLK_W:0]    blk_reg;
    logic [iba_pkg::CNT_W-1:0]  got_reg;
    logic [iba_pkg::PTR_IDX_W:0] k_reg;
    logic                       stop_reg;
    logic                       rd_pend_reg;
    logic [iba_pkg::PTR_ADDR_W:0] clr_reg;

    logic [2:0] st_reg;
    logic [6:0] phys_reg;
    logic [3:0] given_reg;
    logic [3:0] oslot_reg;

    // name memory
    logic                       nm_we;
    logic [iba_pkg::SLOT_W-1:0] nm_addr;
    logic [63:0]                nm_rdata;
    iba_ram #(.DEPTH(iba_pkg::SLOTS), .AW(iba_pkg::SLOT_W), .DW(64)) u_names (
        .clk(clk), .we(nm_we), .addr(nm_addr), .wdata(name_reg), .rdata(nm_rdata)
    );

    // pointer memory
    logic                           pm_we;
    logic [iba_pkg::PTR_ADDR_W-1:0] pm_addr;
    logic [iba_pkg::BLK_W-1:0]      pm_wdata;
    logic [iba_pkg::BLK_W-1:0]      pm_rdata;
    iba_ram #(.DEPTH(iba_pkg::SLOTS*iba_pkg::PER_FILE), .AW(iba_pkg::PTR_ADDR_W),
              .DW(iba_pkg::BLK_W)) u_ptrs (
        .clk(clk), .we(pm_we), .addr(pm_addr), .wdata(pm_wdata), .rdata(pm_rdata)
    );

    logic [iba_pkg::SLOT_W-1:0] prev_slot;
    logic                       free_found;
    logic [iba_pkg::SLOT_W-1:0] free_slot;

    assign prev_slot = scan_reg[iba_pkg::SLOT_W-1:0] - 1'b1;

    always_comb
    begin
        free_found = 1'b0;
        free_slot = '0;
        for (int i = iba_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_slot = iba_pkg::SLOT_W'(i);
            end
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata = {6'd0, oslot_reg, given_reg, phys_reg, st_reg};

    always_comb
    begin
        nm_we = 1'b0;
        nm_addr = scan_reg[iba_pkg::SLOT_W-1:0];
        pm_we = 1'b0;
        pm_addr = {slot_reg, k_reg[iba_pkg::PTR_IDX_W-1:0]};
        pm_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                pm_we = 1'b1;
                pm_addr = clr_reg[iba_pkg::PTR_ADDR_W-1:0];
            end
            S_DECIDE:
            begin
                nm_addr = free_slot;
                nm_we = (cmd_reg == iba_pkg::CMD_CREATE) && !hit_reg && free_found;
            end
            S_ALLOC:
            begin
                pm_addr = {slot_reg, got_reg[iba_pkg::PTR_IDX_W-1:0]};
                pm_wdata = blk_reg[iba_pkg::BLK_W-1:0];
                pm_we = (got_reg < count_reg) && !blk_reg[iba_pkg::BLK_W]
                        && !busy_reg[blk_reg[iba_pkg::BLK_W-1:0]];
            end
            S_WIPE, S_FREEW: pm_we = 1'b1;
            S_RESOLVE: pm_addr = {slot_reg, index_reg};
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (clr_reg == (iba_pkg::PTR_ADDR_W+1)'(iba_pkg::SLOTS*iba_pkg::PER_FILE-1))
                    state_next = S_IDLE;
            S_IDLE: if (s_axis_tvalid) state_next = S_SEARCH;
            S_SEARCH:
                if (scan_reg == (iba_pkg::SLOT_W+1)'(iba_pkg::SLOTS)) state_next = S_DECIDE;
            S_DECIDE: state_next = S_OUT;
            S_ALLOC: state_next = S_ALLOC;
            S_WIPE: state_next = S_WIPE;
            S_FREE: state_next = S_FREE;
            S_FREEW: state_next = S_FREEW;
            S_RESOLVE: state_next = S_RESOLVE;
            S_OUT: if (m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            used_reg <= '0;
            busy_reg <= '0;
            clr_reg <= '0;
            scan_reg <= '0;
            hit_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            cmd_reg <= '0;
            name_reg <= '0;
            count_reg <= '0;
            index_reg <= '0;
            hit_slot_reg <= '0;
            slot_reg <= '0;
            blk_reg <= '0;
            got_reg <= '0;
            k_reg <= '0;
            stop_reg <= 1'b0;
            st_reg <= '0;
            phys_reg <= '0;
            given_reg <= '0;
            oslot_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (state_next == S_IDLE) state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (s_axis_tvalid)
                    begin
                        cmd_reg <= s_axis_tdata[1:0];
                        name_reg <= iba_pkg::clean_name(s_axis_tdata[65:2]);
                        count_reg <= s_axis_tdata[69:66];
                        index_reg <= s_axis_tdata[72:70];
                        scan_reg <= '0;
                        hit_reg <= 1'b0;
                        if (s_axis_tdata[1:0] == iba_pkg::CMD_NONE)
                        begin
                            {st_reg, phys_reg, given_reg, oslot_reg} <= '0;
                            state_reg <= S_OUT;
                        end
                        else if (s_axis_tdata[1:0] == iba_pkg::CMD_CREATE
                                 && s_axis_tdata[69:66] > 4'(iba_pkg::PER_FILE))
                        begin
                            st_reg <= iba_pkg::ST_BAD_SIZE;
                            {phys_reg, given_reg, oslot_reg} <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_SEARCH;
                    end
                S_SEARCH:
                begin
                    // data for entry scan-1 is on nm_rdata
                    if (scan_reg != '0 && !hit_reg && used_reg[prev_slot]
                        && nm_rdata == name_reg)
                    begin
                        hit_reg <= 1'b1;
                        hit_slot_reg <= prev_slot;
                    end
                    if (scan_reg == (iba_pkg::SLOT_W+1)'(iba_pkg::SLOTS))
                        state_reg <= S_DECIDE;
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                S_DECIDE:
                begin
                    phys_reg <= '0;
                    given_reg <= '0;
                    k_reg <= '0;
                    got_reg <= '0;
                    blk_reg <= (iba_pkg::BLK_W+1)'(1);
                    stop_reg <= 1'b0;
                    rd_pend_reg <= 1'b0;
                    case (cmd_reg)
                        iba_pkg::CMD_CREATE:
                            if (hit_reg)
                            begin
                                st_reg <= iba_pkg::ST_EXISTS;
                                oslot_reg <= hit_slot_reg;
                                slot_reg <= hit_slot_reg;
                                state_reg <= S_OUT;
                            end
                            else if (!free_found)
                            begin
                                st_reg <= iba_pkg::ST_FULL;
                                oslot_reg <= '0;
                                slot_reg <= hit_slot_reg;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                st_reg <= iba_pkg::ST_OK;
                                oslot_reg <= '0;
                                used_reg[free_slot] <= 1'b1;
                                slot_reg <= free_slot;
                                state_reg <= S_WIPE;
                            end
                        iba_pkg::CMD_DELETE, iba_pkg::CMD_RESOLVE:
                            if (!hit_reg)
                            begin
                                st_reg <= iba_pkg::ST_NOT_FOUND;
                                oslot_reg <= '0;
                                slot_reg <= hit_slot_reg;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                st_reg <= iba_pkg::ST_OK;
                                oslot_reg <= hit_slot_reg;
                                slot_reg <= hit_slot_reg;
                                if (cmd_reg == iba_pkg::CMD_DELETE)
                                begin
                                    used_reg[hit_slot_reg] <= 1'b0;
                                    state_reg <= S_FREE;
                                end
                                else
                                    state_reg <= S_RESOLVE;
                            end
                        default:
                        begin
                            st_reg <= iba_pkg::ST_OK;
                            oslot_reg <= '0;
                            slot_reg <= hit_slot_reg;
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_WIPE:
                begin
                    // clear the new entry's pointers, then allocate
                    if (k_reg == (iba_pkg::PTR_IDX_W+1)'(iba_pkg::PER_FILE-1))
                        state_reg <= S_ALLOC;
                    k_reg <= k_reg + 1'b1;
                end
                S_ALLOC:
                begin
                    if (got_reg >= count_reg || blk_reg[iba_pkg::BLK_W])
                    begin
                        st_reg <= (got_reg < count_reg) ? iba_pkg::ST_PARTIAL
                                                        : iba_pkg::ST_OK;
                        given_reg <= got_reg;
                        oslot_reg <= slot_reg;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if (!busy_reg[blk_reg[iba_pkg::BLK_W-1:0]])
                        begin
                            busy_reg[blk_reg[iba_pkg::BLK_W-1:0]] <= 1'b1;
                            got_reg <= got_reg + 1'b1;
                        end
                        blk_reg <= blk_reg + 1'b1;
                    end
                end
                S_FREE:
                begin
                    // read pointer k, then evaluate it in the following cycle
                    if (rd_pend_reg)
                    begin
                        if (!stop_reg && pm_rdata != '0)
                        begin
                            busy_reg[pm_rdata] <= 1'b0;
                            given_reg <= given_reg + 1'b1;
                        end
                        else
                            stop_reg <= 1'b1;
                        if (k_reg == (iba_pkg::PTR_IDX_W+1)'(iba_pkg::PER_FILE-1))
                        begin
                            k_reg <= '0;
                            state_reg <= S_FREEW;
                        end
                        else
                            k_reg <= k_reg + 1'b1;
                        rd_pend_reg <= 1'b0;
                    end
                    else
                        rd_pend_reg <= 1'b1;
                end
                S_FREEW:
                begin
                    if (k_reg == (iba_pkg::PTR_IDX_W+1)'(iba_pkg::PER_FILE-1))
                        state_reg <= S_OUT;
                    k_reg <= k_reg + 1'b1;
                end
                S_RESOLVE:
                begin
                    if (rd_pend_reg)
                    begin
                        if (pm_rdata == '0)
                            st_reg <= iba_pkg::ST_NO_BLOCK;
                        else
                            phys_reg <= pm_rdata;
                        state_reg <= S_OUT;
                        rd_pend_reg <= 1'b0;
                    end
                    else
                        rd_pend_reg <= 1'b1;
                end
                S_OUT:
                    if (m_axis_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/iba_checker.sv
// Port-level checks for the inode block allocator, bound to the top level.
// Depends on the top level's ports and on iba_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none
module iba_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);
    // one item in flight: never ready to take while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_acc: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("two items");
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= iba_pkg::ST_BAD_SIZE)
        else $error("bad status");
    a_phys: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != iba_pkg::ST_OK |-> m_axis_tdata[9:3] == 7'd0)
        else $error("block on failure");
endmodule

bind inode_block_allocator iba_checker u_iba_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
